// ----- src/ccin_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ccin_pkg;

  // Field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned DivSteps = ProdW;

  // Search depth default
  localparam int unsigned ShiftTriesDefault = 15;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_REF_ANGLE_REAL = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_REF_ANGLE_IMAG = 1'b1;

  // Reset values of the reference angle
  localparam logic [SampleW-1:0] RefAngleRealRst = 16'sd16384;
  localparam logic [SampleW-1:0] RefAngleImagRst = 16'sd0;

  // Input beat
  typedef struct packed {
    logic signed [SampleW-1:0] chan_real;
    logic signed [SampleW-1:0] chan_imag;
  } chan_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [SampleW-1:0] inv_real;
    logic signed [SampleW-1:0] inv_imag;
    logic [ShiftW-1:0]         norm_shift;
    logic                      not_found;
  } inv_beat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SEARCH,
    ST_DIV_RE,
    ST_DIV_IM
  } ccin_state_e;

  // Unsigned magnitude of a 32-bit two's-complement pattern
  function automatic logic [ProdW-1:0] mag32(input logic [ProdW-1:0] v);
    mag32 = v[ProdW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

// ----- src/ccin_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial restoring divider: signed 32-bit truncating quotient, low 16 bits.
// A zero divisor gives zero. One quotient bit per cycle.
module ccin_div import ccin_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [ProdW-1:0]   num_i,
  input  wire logic [ProdW-1:0]   den_i,
  output logic                    done_o,
  output logic [SampleW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] rem_q, rem_d;
  logic [ProdW-1:0] quo_q, quo_d;
  logic [ProdW-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic             zero_q, zero_d;

  logic [ProdW:0]   trial;
  logic             fits;

  // One restoring step
  assign trial = {rem_q, quo_q[ProdW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivSteps);
      rem_d  = '0;
      quo_d  = mag32(num_i);
      den_d  = mag32(den_i);
      neg_d  = num_i[ProdW-1] ^ den_i[ProdW-1];
      zero_d = (den_i == '0);
    end else if (busy_q) begin
      rem_d = fits ? ProdW'(trial - {1'b0, den_q}) : trial[ProdW-1:0];
      quo_d = {quo_q[ProdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // Sign and zero-divisor fix-up on the low half
  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = ~quo_q[SampleW-1:0] + 1'b1;
    end else begin
      quo_o = quo_q[SampleW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- src/complex_channel_inverse_normalized.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Normalized inverse of a Q15 complex channel gain: returns ref_angle / gain in
// Q15 plus a normalization shift. A beat is taken when start is high and busy
// is low; busy stays high until the result strobe. Each item runs a
// multiply-accumulate pass on a single 16x16 multiplier, then tries one shift
// after another (1 to SHIFT_TRIES of them), then makes two passes of the
// bit-serial divider when a shift qualifies. The result is on inv_o for exactly
// one cycle with result_valid_o high; the receiver cannot stall it and must take
// it then. The reference angle registers are written through the cfg port; the
// user must do so only while idle, which the block itself does not enforce.
module complex_channel_inverse_normalized import ccin_pkg::*; #(
  parameter int unsigned SHIFT_TRIES = ShiftTriesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire chan_beat_t         chan_i,
  output logic                    result_valid_o,
  output inv_beat_t               inv_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [SampleW-1:0] cfg_data_i
);

  localparam int unsigned SW = $clog2(SHIFT_TRIES);

  ccin_state_e state_q, state_d;

  logic signed [SampleW-1:0] ang_re_q, ang_im_q;
  logic signed [SampleW-1:0] cr_q, ci_q;
  logic [2:0]                k_q;
  logic [SW-1:0]             s_q;
  logic [ProdW-1:0]          z0_q, z1_q, z2_q;
  logic [ProdW-1:0]          den_q;
  logic                      valid_q;
  inv_beat_t                 res_q;

  logic signed [SampleW-1:0] op_a, op_b;
  logic signed [ProdW-1:0]   prod;
  logic [ProdW-1:0]          m2, den_now;
  logic                      found, last_try, mac_last;
  logic                      div_start, div_done;
  logic [ProdW-1:0]          div_num, div_den;
  logic [SampleW-1:0]        div_quo;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_re_q <= RefAngleRealRst;
      ang_im_q <= RefAngleImagRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_ANGLE_REAL: ang_re_q <= cfg_data_i;
        CFG_REF_ANGLE_IMAG: ang_im_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // Shared multiplier operand select: P2 = cr*cr + ci*ci, P0 = ar*cr + ai*ci,
  // P1 = ai*cr - ar*ci. Shifting the gain by s scales P0, P1 by 2^s, P2 by 4^s.
  always_comb begin
    unique case (k_q)
      3'd0:    begin op_a = cr_q;     op_b = cr_q; end
      3'd1:    begin op_a = ci_q;     op_b = ci_q; end
      3'd2:    begin op_a = ang_re_q; op_b = cr_q; end
      3'd3:    begin op_a = ang_im_q; op_b = ci_q; end
      3'd4:    begin op_a = ang_im_q; op_b = cr_q; end
      default: begin op_a = ang_re_q; op_b = ci_q; end
    endcase
  end

  assign prod = op_a * op_b;

  // Search compare
  assign m2       = mag32(z2_q);
  assign found    = (mag32(z0_q) < m2) && (mag32(z1_q) < m2);
  assign last_try = (s_q == SW'(SHIFT_TRIES - 1));
  assign mac_last = (k_q == 3'd5);
  assign den_now  = ProdW'($signed(z2_q) >>> 15);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_MAC;
      ST_MAC:    if (mac_last) state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (found) begin
          state_d = ST_DIV_RE;
        end else if (last_try) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_RE: if (div_done) state_d = ST_DIV_IM;
      ST_DIV_IM: if (div_done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    div_start = 1'b0;
    div_num   = z0_q;
    div_den   = den_now;
    unique case (state_q)
      ST_SEARCH: begin
        div_start = found;
      end
      ST_DIV_RE: begin
        div_start = div_done;
        div_num   = z1_q;
        div_den   = den_q;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      k_q     <= '0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= ((state_q == ST_SEARCH) && !found && last_try) ||
                 ((state_q == ST_DIV_IM) && div_done);
      if (state_q == ST_IDLE) begin
        k_q <= '0;
        s_q <= '0;
      end else if (state_q == ST_MAC) begin
        k_q <= k_q + 1'b1;
      end else if (state_q == ST_SEARCH && !found && !last_try) begin
        s_q <= s_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      cr_q <= chan_i.chan_real;
      ci_q <= chan_i.chan_imag;
    end
    unique case (state_q)
      ST_MAC: begin
        unique case (k_q)
          3'd0:    z2_q <= prod;
          3'd1:    z2_q <= z2_q + prod;
          3'd2:    z0_q <= prod;
          3'd3:    z0_q <= z0_q + prod;
          3'd4:    z1_q <= prod;
          default: z1_q <= z1_q - prod;
        endcase
      end
      ST_SEARCH: begin
        if (found) begin
          den_q          <= den_now;
          res_q.not_found  <= 1'b0;
          res_q.norm_shift <= (s_q == '0) ? '0 : ShiftW'(s_q - 1'b1);
        end else if (last_try) begin
          res_q <= '{inv_real: '0, inv_imag: '0, norm_shift: '0, not_found: 1'b1};
        end else begin
          z0_q <= {z0_q[ProdW-2:0], 1'b0};
          z1_q <= {z1_q[ProdW-2:0], 1'b0};
          z2_q <= {z2_q[ProdW-3:0], 2'b00};
        end
      end
      ST_DIV_RE: if (div_done) res_q.inv_real <= div_quo;
      ST_DIV_IM: if (div_done) res_q.inv_imag <= div_quo;
      default: ;
    endcase
  end

  ccin_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign result_valid_o = valid_q;
  assign inv_o          = res_q;

endmodule

`default_nettype wire

// ----- tb/sv/complex_channel_inverse_normalized_tb.sv -----
`timescale 1ns / 1ps

module complex_channel_inverse_normalized_tb import ccin_pkg::*;;

  localparam int unsigned Tries = ShiftTriesDefault;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  chan_beat_t           chan_i;
  logic                 result_valid_o;
  inv_beat_t            inv_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [SampleW-1:0]   cfg_data_i;

  // Local copy of the reference angle registers
  logic [SampleW-1:0]   angle_re_q;
  logic [SampleW-1:0]   angle_im_q;

  inv_beat_t            pending_inv_q[$];
  int                   mismatch_cnt;

  complex_channel_inverse_normalized i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .chan_i         (chan_i),
    .result_valid_o (result_valid_o),
    .inv_o          (inv_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Expected-inverse computation
  // ---------------------------------------------------------------------------

  // Unsigned magnitude of a 32-bit two's-complement word
  function automatic logic [31:0] abs_word(logic [31:0] v);
    abs_word = v[31] ? (32'd0 - v) : v;
  endfunction

  // Truncating signed quotient, wrapped to 16 bits; zero divisor yields zero
  function automatic logic [15:0] trunc_quot16(logic [31:0] num, logic [31:0] den);
    logic [31:0] q;
    if (den == 32'd0) begin
      trunc_quot16 = 16'd0;
    end else begin
      q = abs_word(num) / abs_word(den);
      if (num[31] ^ den[31]) begin
        q = 32'd0 - q;
      end
      trunc_quot16 = q[15:0];
    end
  endfunction

  // Shift search, then both divisions by the scaled power
  function automatic inv_beat_t calc_inverse(chan_beat_t c, logic [15:0] are,
                                             logic [15:0] aim);
    logic [31:0] ar, ai, cr, ci, xr, xi, pwr, re_acc, im_acc, lim, den;
    logic        found;
    inv_beat_t   r;
    int          s;
    ar = {{16{are[15]}}, are};
    ai = {{16{aim[15]}}, aim};
    cr = {{16{c.chan_real[15]}}, c.chan_real};
    ci = {{16{c.chan_imag[15]}}, c.chan_imag};
    r = '0;
    r.not_found = 1'b1;
    found = 1'b0;
    for (s = 0; s < Tries; s++) begin
      if (!found) begin
        xr = cr << s;
        xi = ci << s;
        pwr    = xr * xr + xi * xi;
        re_acc = ar * xr + ai * xi;
        im_acc = ai * xr - ar * xi;
        lim    = abs_word(pwr);
        if (abs_word(re_acc) < lim && abs_word(im_acc) < lim) begin
          found = 1'b1;
          den = {{15{pwr[31]}}, pwr[31:15]};
          r.inv_real   = trunc_quot16(re_acc, den);
          r.inv_imag   = trunc_quot16(im_acc, den);
          r.norm_shift = (s > 0) ? ShiftW'(s - 1) : '0;
          r.not_found  = 1'b0;
        end
      end
    end
    calc_inverse = r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe consumes the oldest expected beat
  // ---------------------------------------------------------------------------

  task automatic report_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    inv_beat_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_inv_q.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got %h", $time, inv_o);
        mismatch_cnt++;
      end else begin
        want = pending_inv_q.pop_front();
        report_field("inv_real", $signed(want.inv_real), $signed(inv_o.inv_real));
        report_field("inv_imag", $signed(want.inv_imag), $signed(inv_o.inv_imag));
        report_field("norm_shift", want.norm_shift, inv_o.norm_shift);
        report_field("not_found", want.not_found, inv_o.not_found);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Issue one channel beat; start stays high on return
  task automatic send_chan(logic [15:0] re, logic [15:0] im);
    logic ready;
    @(negedge clk_i);
    start = 1'b1;
    chan_i.chan_real = re;
    chan_i.chan_imag = im;
    forever begin
      ready = !busy;
      @(posedge clk_i);
      if (ready) break;
      @(negedge clk_i);
    end
    pending_inv_q.push_back(calc_inverse(chan_i, angle_re_q, angle_im_q));
  endtask

  // Random sender gap; chan_i carries noise while start is low. The gap
  // counts from the point where the block is free again, so it is seen.
  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start = 1'b0;
      chan_i = chan_beat_t'($urandom);
      while (busy) @(negedge clk_i);
      repeat ($urandom_range(1, 90)) @(negedge clk_i);
    end
  endtask

  // Hold off until every outstanding result has come back and the block is idle
  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_inv_q.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    if (idx == CFG_REF_ANGLE_REAL) angle_re_q = data;
    else                           angle_im_q = data;
  endtask

  task automatic set_angle(logic [15:0] re, logic [15:0] im);
    drain_results();
    if ($urandom_range(1)) begin
      write_reg(CFG_REF_ANGLE_REAL, re);
      write_reg(CFG_REF_ANGLE_IMAG, im);
    end else begin
      write_reg(CFG_REF_ANGLE_IMAG, im);
      write_reg(CFG_REF_ANGLE_REAL, re);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Value generators
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] edge_value();
    case ($urandom_range(5))
      0:       edge_value = 16'h8000;
      1:       edge_value = 16'h7fff;
      2:       edge_value = 16'h0000;
      3:       edge_value = 16'hffff;
      4:       edge_value = 16'h0001;
      default: edge_value = 16'h4000;
    endcase
  endfunction

  // Mix of full-range, scaled-down (exercises deeper shifts) and edge values
  function automatic logic [15:0] random_sample();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(3))
      0:       random_sample = v;
      1, 2:    random_sample = v >>> $urandom_range(0, 15);
      default: random_sample = edge_value();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset angle: zero gain, full-scale gains, tiny gains, some of which never qualify
  task automatic test_reset_angle();
    send_chan(16'h0000, 16'h0000);
    send_chan(16'h7fff, 16'h0000);
    send_chan(16'h8000, 16'h0000);
    send_chan(16'h0000, 16'h8000);
    send_chan(16'h8000, 16'h8000);
    send_chan(16'h7fff, 16'h7fff);
    send_chan(16'h0001, 16'h0000);
    send_chan(16'h0000, 16'h0001);
    send_chan(16'hffff, 16'hffff);
    send_chan(16'd181,  -16'sd181);
  endtask

  // Extreme angles, then a zero angle where small gains hit a zero divisor
  task automatic test_angle_extremes();
    set_angle(16'h8000, 16'h8000);
    send_chan(16'h8000, 16'h7fff);
    send_chan(16'h0100, 16'hff00);
    set_angle(16'h7fff, 16'h7fff);
    send_chan(16'h7fff, 16'h8000);
    send_chan(16'h0003, 16'h0002);
    set_angle(16'h8000, 16'h7fff);
    send_chan(16'h1234, 16'h8000);
    send_chan(16'hfff0, 16'h0010);
    set_angle(16'h0000, 16'h0000);
    send_chan(16'h0001, 16'h0000);
    send_chan(16'h0000, 16'hffff);
    send_chan(16'h0003, 16'h0002);
    send_chan(16'h7fff, 16'h8000);
  endtask

  // Random gains, angle reprogrammed now and then
  task automatic test_random_traffic(int gap_pct, int n_items);
    int i;
    for (i = 0; i < n_items; i++) begin
      if (i % 80 == 0) begin
        set_angle(random_sample(), random_sample());
      end
      sender_gap(gap_pct);
      send_chan(random_sample(), random_sample());
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    chan_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_REF_ANGLE_REAL;
    cfg_data_i   = '0;
    angle_re_q   = RefAngleRealRst;
    angle_im_q   = RefAngleImagRst;
    mismatch_cnt = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_angle();
    test_angle_extremes();
    test_random_traffic(9, 534);
    test_random_traffic(62, 533);
    test_random_traffic(0, 533);

    // Wait for the tail, then give stray beats a chance to show up
    drain_results();
    repeat (120) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_inv_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ccin_pkg.sv
src/ccin_div.sv
src/complex_channel_inverse_normalized.sv
tb/sv/complex_channel_inverse_normalized_tb.sv
